// ----- hw/rtl/tdsu_pkg.sv -----
package tdsu_pkg;

  localparam int StackDepth = 64;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  typedef enum logic [4:0] {
    OP_PUSHINT  = 5'd0,
    OP_PUSHBOOL = 5'd1,
    OP_PUSHQUOT = 5'd2,
    OP_DUP      = 5'd3,
    OP_DROP     = 5'd4,
    OP_SWAP     = 5'd5,
    OP_OVER     = 5'd6,
    OP_ROT      = 5'd7,
    OP_NIP      = 5'd8,
    OP_TUCK     = 5'd9,
    OP_ADD      = 5'd10,
    OP_SUB      = 5'd11,
    OP_MUL      = 5'd12,
    OP_DIV      = 5'd13,
    OP_LT       = 5'd14,
    OP_GT       = 5'd15,
    OP_EQ       = 5'd16
  } op_t;

  localparam logic [1:0] TAG_INT  = 2'd0;
  localparam logic [1:0] TAG_BIT  = 2'd1;
  localparam logic [1:0] TAG_QUOT = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;

endpackage

// ----- hw/rtl/typed_data_stack_unit.sv -----
// channel | handshake               | payload (lowest bits first)
// in      | in_tvalid / in_tready   | tdata: opcode, operand_value
// out     | out_tvalid / out_tready | tdata: status, top_value, stack_depth; tuser: top_tag
// a result is loaded after two stack memory reads, one
// per cycle (the top lives in its own register), an execute step, a list step, then
// up to three writes; mul adds partial products through one 32x32
// multiplier, div adds one quotient bit a cycle. underflow, overflow and unknown
// opcodes answer straight from idle, type and zero-divisor errors from the execute step.
// reset clears the depth, the top and the output valid; the memory is not cleared.
// out is a register: the next item runs while a result waits, and a second finished
// result waits until the output register is free.
module typed_data_stack_unit
  import tdsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // opcode[4:0], operand_value[68:5], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // status[2:0], top_value[66:3], stack_depth[73:67],
                                   // zero pad
  output logic [1:0]   out_tuser   // top_tag[1:0]
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV, S_WR0, S_WR1, S_WR2, S_OUT
  } state_t;

  state_t       state_r;
  logic [4:0]   op_r;
  logic [63:0]  opv_r;
  logic [CntW-1:0] depth_r, dnew_r;
  logic [2:0]   status_r;
  // operand cells: c0 top, c1 second, c2 third
  logic [63:0]  v0_r, v1_r, v2_r;
  logic [1:0]   t0_r, t1_r, t2_r;
  logic [PtrW-1:0] rd_addr;
  logic         rd_en;
  logic [65:0]  mem_q;
  logic [65:0]  mem [StackDepth];
  // pending writes: up to three cells
  logic [65:0]  w_data_r [3];
  logic [PtrW-1:0] w_addr_r [3];
  logic [1:0]   w_cnt_r;
  logic [1:0]   top_tag_r;
  logic [63:0]  top_val_r;
  // output register
  logic [79:0]  out_data_r;
  logic [1:0]   out_user_r;
  // shared arithmetic unit state
  logic [6:0]   it_r;
  logic [63:0]  acc_r, quo_r, dvs_r;
  logic [64:0]  rem_r;
  logic         neg_r;
  logic [63:0]  res_r;
  logic [1:0]   res_tag_r;

  // operation decode
  logic [1:0] need;
  logic       grow;
  logic       known;
  always_comb begin
    known = in_tdata[4:0] <= OP_EQ;
    need = 2'd2;
    grow = 1'b0;
    unique case (in_tdata[4:0]) inside
      OP_PUSHINT, OP_PUSHBOOL, OP_PUSHQUOT: begin need = 2'd0; grow = 1'b1; end
      OP_DUP:  begin need = 2'd1; grow = 1'b1; end
      OP_DROP: need = 2'd1;
      OP_ROT:  need = 2'd3;
      OP_OVER, OP_TUCK: grow = 1'b1;
      default: need = 2'd2;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (state_r == S_WR0 || state_r == S_WR1 || state_r == S_WR2) begin
      if (w_cnt_r != 2'd0) mem[w_addr_r[0]] <= w_data_r[0];
    end
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_RD0: begin rd_en = 1'b1; rd_addr = PtrW'(depth_r - CntW'(2)); end
      S_RD1: begin rd_en = 1'b1; rd_addr = PtrW'(depth_r - CntW'(3)); end
      default: ;
    endcase
  end

  // mul partial product: one 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] pp;
  always_comb begin
    unique case (it_r[1:0])
      2'd0: begin ma = v1_r[31:0];  mb = v0_r[31:0];  end
      2'd1: begin ma = v1_r[63:32]; mb = v0_r[31:0];  end
      2'd2: begin ma = v1_r[31:0];  mb = v0_r[63:32]; end
      default: begin ma = '0; mb = '0; end
    endcase
    pp = ma * mb;
  end

  // restoring divide step
  logic [64:0] rem_sh, rem_sub;
  always_comb begin
    rem_sh  = {rem_r[63:0], quo_r[63]};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  logic [63:0] a_s, b_s, alu_res;
  logic lt_s, gt_s;
  always_comb begin
    a_s  = v1_r;
    b_s  = v0_r;
    lt_s = $signed(a_s) < $signed(b_s);
    gt_s = $signed(a_s) > $signed(b_s);
    alu_res = '0;
    case (op_r)
      OP_ADD: alu_res = a_s + b_s;
      OP_SUB: alu_res = a_s - b_s;
      OP_LT:  alu_res = {63'd0, lt_s};
      OP_GT:  alu_res = {63'd0, gt_s};
      OP_EQ:  alu_res = {63'd0, (t0_r == t1_r) && (v0_r == v1_r)};
      default: alu_res = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      depth_r   <= '0;
      top_tag_r <= TAG_INT;
      top_val_r <= '0;
      out_tvalid <= 1'b0;
      out_data_r <= '0;
      out_user_r <= '0;
      w_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r  <= in_tdata[4:0];
            opv_r <= in_tdata[68:5];
            v0_r  <= top_val_r;
            t0_r  <= top_tag_r;
            w_cnt_r <= '0;
            status_r <= ST_OK;
            if (!known) state_r <= S_OUT;
            else if (depth_r < CntW'(need)) begin
              status_r <= ST_UNDER; state_r <= S_OUT;
            end else if (grow && depth_r >= CntW'(StackDepth)) begin
              status_r <= ST_OVER; state_r <= S_OUT;
            end else state_r <= S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          t1_r <= mem_q[65:64];
          v1_r <= mem_q[63:0];
          state_r <= S_RD2;
        end
        S_RD2: begin
          t2_r <= mem_q[65:64];
          v2_r <= mem_q[63:0];
          state_r <= S_EXEC;
          it_r  <= '0;
          acc_r <= '0;
        end
        S_EXEC: begin
          // default result of binary ops and tag check
          state_r <= S_WR0;
          res_tag_r <= (op_r == OP_LT || op_r == OP_GT || op_r == OP_EQ) ? TAG_BIT : TAG_INT;
          res_r <= alu_res;
          if (op_r >= OP_ADD && op_r <= OP_GT && (t0_r != TAG_INT || t1_r != TAG_INT)) begin
            status_r <= ST_TYPE; state_r <= S_OUT;
          end else if (op_r == OP_DIV && v0_r == 64'd0) begin
            status_r <= ST_DIVZ; state_r <= S_OUT;
          end else if (op_r == OP_MUL) begin
            state_r <= S_MUL;
          end else if (op_r == OP_DIV) begin
            neg_r <= v1_r[63] ^ v0_r[63];
            quo_r <= v1_r[63] ? -v1_r : v1_r;
            dvs_r <= v0_r[63] ? -v0_r : v0_r;
            rem_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_MUL: begin
          it_r <= it_r + 7'd1;
          if (it_r[1:0] == 2'd0) acc_r <= pp;
          else acc_r <= acc_r + {pp[31:0], 32'd0};
          if (it_r[1:0] == 2'd2) begin
            res_r <= acc_r + {pp[31:0], 32'd0};
            state_r <= S_WR0;
          end
        end
        S_DIV: begin
          it_r <= it_r + 7'd1;
          if (!rem_sub[64]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (it_r == 7'd63) begin
            res_r <= neg_r ? -{quo_r[62:0], !rem_sub[64]} : {quo_r[62:0], !rem_sub[64]};
            state_r <= S_WR0;
          end
        end
        S_WR0: begin
          // build write list and new top
          state_r <= S_WR1;
          w_cnt_r <= 2'd0;
          dnew_r  <= depth_r;
          case (op_r)
            OP_PUSHINT, OP_PUSHBOOL, OP_PUSHQUOT: begin
              logic [1:0] tg;
              logic [63:0] vv;
              tg = (op_r == OP_PUSHINT) ? TAG_INT : (op_r == OP_PUSHBOOL) ? TAG_BIT : TAG_QUOT;
              vv = (op_r == OP_PUSHBOOL) ? {63'd0, opv_r[0]} : opv_r;
              w_data_r[0] <= {tg, vv}; w_addr_r[0] <= PtrW'(depth_r); w_cnt_r <= 2'd1;
              top_tag_r <= tg; top_val_r <= vv; dnew_r <= depth_r + CntW'(1);
            end
            OP_DUP: begin
              w_data_r[0] <= {t0_r, v0_r}; w_addr_r[0] <= PtrW'(depth_r); w_cnt_r <= 2'd1;
              dnew_r <= depth_r + CntW'(1);
            end
            OP_DROP: begin
              dnew_r <= depth_r - CntW'(1);
              if (depth_r == CntW'(1)) begin top_tag_r <= TAG_INT; top_val_r <= '0; end
              else begin top_tag_r <= t1_r; top_val_r <= v1_r; end
            end
            OP_SWAP: begin
              w_data_r[0] <= {t1_r, v1_r}; w_addr_r[0] <= PtrW'(depth_r - CntW'(1));
              w_data_r[1] <= {t0_r, v0_r}; w_addr_r[1] <= PtrW'(depth_r - CntW'(2));
              w_cnt_r <= 2'd2; top_tag_r <= t1_r; top_val_r <= v1_r;
            end
            OP_OVER: begin
              w_data_r[0] <= {t1_r, v1_r}; w_addr_r[0] <= PtrW'(depth_r); w_cnt_r <= 2'd1;
              top_tag_r <= t1_r; top_val_r <= v1_r; dnew_r <= depth_r + CntW'(1);
            end
            OP_ROT: begin
              w_data_r[0] <= {t1_r, v1_r}; w_addr_r[0] <= PtrW'(depth_r - CntW'(3));
              w_data_r[1] <= {t0_r, v0_r}; w_addr_r[1] <= PtrW'(depth_r - CntW'(2));
              w_data_r[2] <= {t2_r, v2_r}; w_addr_r[2] <= PtrW'(depth_r - CntW'(1));
              w_cnt_r <= 2'd3; top_tag_r <= t2_r; top_val_r <= v2_r;
            end
            OP_NIP: begin
              w_data_r[0] <= {t0_r, v0_r}; w_addr_r[0] <= PtrW'(depth_r - CntW'(2));
              w_cnt_r <= 2'd1; dnew_r <= depth_r - CntW'(1);
            end
            OP_TUCK: begin
              w_data_r[0] <= {t0_r, v0_r}; w_addr_r[0] <= PtrW'(depth_r - CntW'(2));
              w_data_r[1] <= {t1_r, v1_r}; w_addr_r[1] <= PtrW'(depth_r - CntW'(1));
              w_data_r[2] <= {t0_r, v0_r}; w_addr_r[2] <= PtrW'(depth_r);
              w_cnt_r <= 2'd3; dnew_r <= depth_r + CntW'(1);
            end
            default: begin
              w_data_r[0] <= {res_tag_r, res_r}; w_addr_r[0] <= PtrW'(depth_r - CntW'(2));
              w_cnt_r <= 2'd1; dnew_r <= depth_r - CntW'(1);
              top_tag_r <= res_tag_r; top_val_r <= res_r;
            end
          endcase
        end
        S_WR1, S_WR2: begin
          // drain the write list, one cell a cycle
          if (w_cnt_r != 2'd0) begin
            w_data_r[0] <= w_data_r[1]; w_addr_r[0] <= w_addr_r[1];
            w_data_r[1] <= w_data_r[2]; w_addr_r[1] <= w_addr_r[2];
            w_cnt_r <= w_cnt_r - 2'd1;
          end
          if (w_cnt_r <= 2'd1) begin
            depth_r <= dnew_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // load the output register once it is free
          if (!out_tvalid || out_tready) begin
            out_data_r <= {6'd0, 7'(depth_r), top_val_r, status_r};
            out_user_r <= top_tag_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // output valid: set on load, cleared after the transfer
      if (state_r == S_OUT && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while waiting");
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CntW'(StackDepth)) else $error("depth above capacity");
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && depth_r == '0) |-> (top_val_r == '0 && top_tag_r == TAG_INT))
    else $error("empty top");
  a_err_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && status_r != ST_OK) |-> $stable(depth_r)) else $error("error changed depth");

endmodule
